// ----- rtl/bbse_pkg.sv -----
// Package for the bit-block stamp encoder: field widths, reset values,
// item structs, CRC constants, action, register and status codes, sequencer states.
// No dependencies.
package bbse_pkg;

    localparam int BLOCK_SIZE_DEF = 4;

    localparam int POS_W    = 13;
    localparam int STRIDE_W = 14;
    localparam int CRD_W    = 12;
    localparam int LEN_W    = 12;
    localparam int LUMA_W   = 8;
    localparam int ADDR_W   = 25;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int CRC_W    = 32;

    localparam int BYTE_BITS = 8;
    localparam int CRC_BYTES = 4;
    localparam int CRC_BITS  = CRC_BYTES * BYTE_BITS;

    localparam logic [POS_W-1:0]    WIDTH_RST  = POS_W'(640);
    localparam logic [POS_W-1:0]    HEIGHT_RST = POS_W'(480);
    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(640);
    localparam logic [LUMA_W-1:0]   ON_RST     = LUMA_W'(255);
    localparam logic [LUMA_W-1:0]   OFF_RST    = LUMA_W'(0);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM   = 2'd1;
    localparam logic [1:0] STAT_OFF_FRAME = 2'd2;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_ROW_STRIDE,
        REG_START_X,
        REG_START_Y,
        REG_MSG_LEN,
        REG_ON_LEVEL,
        REG_OFF_LEVEL
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_PREP,
        ST_MUL,
        ST_CHECK,
        ST_BITS,
        ST_CRC
    } t_state;

    typedef struct packed {
        logic             action;
        logic [7:0]       msg_byte;
    } t_in_item;

    typedef struct packed {
        logic [CRD_W-1:0]  block_x;
        logic [CRD_W-1:0]  block_y;
        logic [ADDR_W-1:0] block_address;
        logic              bit_value;
        logic [LUMA_W-1:0] luma;
        logic [1:0]        status;
        logic              last;
    } t_out_item;

endpackage

// ----- rtl/block_bit_stamp_encoder_top.sv -----
// Bit-block stamp encoder, top level: APB register file, start sequencer
// with bit-serial capacity check, bit-serial byte/CRC stamping.
// Depends on bbse_pkg.
//
// A start item runs the capacity check: four restoring dividers by
// BLOCK_SIZE, one quotient bit a cycle, then a shift-add multiply one
// bit a cycle; a start that fails the frame bounds skips both. A message
// byte's eight blocks leave one a cycle from a shift register while the
// CRC-32 absorbs one bit a cycle, then the sequencer returns to idle.
// The final byte is followed by the CRC blocks. Any cycle with the output
// register full and not taken stalls the check and the block emission;
// the dividers and the multiply do not wait for the output.
module block_bit_stamp_encoder_top #(
    parameter int BLOCK_SIZE = bbse_pkg::BLOCK_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbse_pkg::PADDR_W-1:0] paddr,
    input  logic [bbse_pkg::PDATA_W-1:0] pwdata,
    output logic [bbse_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bbse_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bbse_pkg::t_out_item          o_out_item
);
    import bbse_pkg::*;

    localparam int POS_MAX = (2 ** POS_W) - 1;
    localparam int PW      = $clog2(POS_MAX + 2 * BLOCK_SIZE + 1);
    localparam int RW      = $clog2(BLOCK_SIZE) + 1;
    localparam int CNT_W   = $clog2(CRC_BITS);
    localparam int ACC_W   = 2 * POS_W;
    localparam int NEED_W  = LEN_W + 4;
    localparam int PROD_W  = POS_W + STRIDE_W;
    localparam int NL      = 4;
    localparam int LN_W    = 0;
    localparam int LN_H    = 1;
    localparam int LN_ROW  = 2;
    localparam int LN_COL  = 3;

    t_state               r_state, n_state;

    logic [POS_W-1:0]     r_width, r_height;
    logic [STRIDE_W-1:0]  r_stride;
    logic [CRD_W-1:0]     r_start_x, r_start_y;
    logic [LEN_W-1:0]     r_msg_len;
    logic [LUMA_W-1:0]    r_on, r_off;

    logic [POS_W-1:0]     r_col, n_col, r_row, n_row;
    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [7:0]           r_cb, n_cb;
    logic [CRC_W-1:0]     r_sr, n_sr;
    logic [LEN_W-1:0]     r_left, n_left;
    logic                 r_run, n_run;
    logic                 r_noroom, n_noroom;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [POS_W-1:0]     r_dq [NL];
    logic [POS_W-1:0]     n_dq [NL];
    logic [RW-1:0]        r_rem [NL];
    logic [RW-1:0]        n_rem [NL];
    logic [POS_W-1:0]     r_mq, n_mq;
    logic [ACC_W-1:0]     r_acc, n_acc;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 cfg_wr;
    t_reg_idx             cfg_idx;
    logic                 in_acc, emit_ok;

    logic [PW-1:0]        col_a, row_a;
    logic                 step_wrap, step_fail, row_bad, col_over, start_bad;
    logic [POS_W-1:0]     step_col, step_row, sel_col, sel_row;

    logic [RW:0]          div_sh  [NL];
    logic                 div_ge  [NL];
    logic [POS_W-1:0]     div_dq  [NL];
    logic [RW-1:0]        div_rem [NL];

    logic                 crc_fb;
    logic [CRC_W-1:0]     crc_next;
    logic [ACC_W-1:0]     room;
    logic [NEED_W-1:0]    need;
    logic                 room_short;
    logic [PROD_W-1:0]    row_prod, addr_full;
    logic                 cur_bit;
    t_out_item            blk;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_height);
            REG_ROW_STRIDE:   prdata = PDATA_W'(r_stride);
            REG_START_X:      prdata = PDATA_W'(r_start_x);
            REG_START_Y:      prdata = PDATA_W'(r_start_y);
            REG_MSG_LEN:      prdata = PDATA_W'(r_msg_len);
            REG_ON_LEVEL:     prdata = PDATA_W'(r_on);
            REG_OFF_LEVEL:    prdata = PDATA_W'(r_off);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_stride  <= STRIDE_RST;
            r_start_x <= '0;
            r_start_y <= '0;
            r_msg_len <= '0;
            r_on      <= ON_RST;
            r_off     <= OFF_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  r_width   <= pwdata[POS_W-1:0];
                REG_FRAME_HEIGHT: r_height  <= pwdata[POS_W-1:0];
                REG_ROW_STRIDE:   r_stride  <= pwdata[STRIDE_W-1:0];
                REG_START_X:      r_start_x <= pwdata[CRD_W-1:0];
                REG_START_Y:      r_start_y <= pwdata[CRD_W-1:0];
                REG_MSG_LEN:      r_msg_len <= pwdata[LEN_W-1:0];
                REG_ON_LEVEL:     r_on      <= pwdata[LUMA_W-1:0];
                REG_OFF_LEVEL:    r_off     <= pwdata[LUMA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- datapath pieces ----------------
    assign in_acc  = i_in_valid && o_in_ready;
    assign emit_ok = !r_out_valid || i_out_ready;

    // cursor step: one block right, wrap to next block row, hold on failure
    assign col_a     = PW'(r_col) + PW'(BLOCK_SIZE);
    assign row_a     = PW'(r_row) + PW'(BLOCK_SIZE);
    assign step_wrap = (col_a + PW'(BLOCK_SIZE)) > PW'(r_width);
    assign step_fail = step_wrap && ((row_a + PW'(BLOCK_SIZE)) > PW'(r_height));
    assign step_col  = step_fail ? r_col : (step_wrap ? '0 : col_a[POS_W-1:0]);
    assign step_row  = (step_wrap && !step_fail) ? row_a[POS_W-1:0] : r_row;

    assign row_bad   = row_a > PW'(r_height);
    assign col_over  = col_a > PW'(r_width);
    assign start_bad = row_bad || (col_over && step_fail);
    assign sel_col   = (!row_bad && col_over) ? step_col : r_col;
    assign sel_row   = (!row_bad && col_over) ? step_row : r_row;

    // restoring dividers by BLOCK_SIZE, one quotient bit per cycle
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            div_sh[k]  = {r_rem[k], r_dq[k][POS_W-1]};
            div_ge[k]  = div_sh[k] >= (RW + 1)'(BLOCK_SIZE);
            div_rem[k] = div_ge[k] ? RW'(div_sh[k] - (RW + 1)'(BLOCK_SIZE))
                                   : RW'(div_sh[k]);
            div_dq[k]  = {r_dq[k][POS_W-2:0], div_ge[k]};
        end
    end

    // reflected CRC-32, one data bit per cycle unless the output stalls, LSB first
    assign crc_fb   = r_crc[0] ^ r_cb[0];
    assign crc_next = (r_crc >> 1) ^ (crc_fb ? CRC_POLY : '0);

    assign room       = r_acc - ACC_W'(r_dq[LN_COL]);
    assign need       = {(LEN_W + 1)'(r_left) + (LEN_W + 1)'(CRC_BYTES), 3'b000};
    assign room_short = r_noroom || (room < ACC_W'(need));

    assign row_prod  = PROD_W'(r_row) * PROD_W'(r_stride);
    assign addr_full = row_prod + PROD_W'(r_col);
    assign cur_bit   = r_sr[CRC_W-1];

    always_comb begin
        blk.block_x       = r_col[CRD_W-1:0];
        blk.block_y       = r_row[CRD_W-1:0];
        blk.block_address = addr_full[ADDR_W-1:0];
        blk.bit_value     = cur_bit;
        blk.luma          = cur_bit ? r_on : r_off;
        blk.status        = step_fail ? STAT_OFF_FRAME : STAT_OK;
        blk.last          = 1'b0;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.action == ACT_START) begin
                        n_state = ST_START;
                    end else if (r_run) begin
                        n_state = ST_BITS;
                    end
                end
            end
            ST_START: n_state = start_bad ? ST_CHECK : ST_DIV;
            ST_DIV:   n_state = (r_cnt == '0) ? ST_PREP : ST_DIV;
            ST_PREP:  n_state = ST_MUL;
            ST_MUL:   n_state = (r_cnt == '0) ? ST_CHECK : ST_MUL;
            ST_CHECK: begin
                if (emit_ok) begin
                    if (!room_short && r_left == '0) begin
                        n_state = ST_CRC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BITS: begin
                if (emit_ok) begin
                    if (step_fail) begin
                        n_state = ST_IDLE;
                    end else if (r_cnt == '0) begin
                        n_state = (r_left == LEN_W'(1)) ? ST_CRC : ST_IDLE;
                    end
                end
            end
            ST_CRC: begin
                if (emit_ok && (step_fail || r_cnt == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_crc       = r_crc;
        n_cb        = r_cb;
        n_sr        = r_sr;
        n_left      = r_left;
        n_run       = r_run;
        n_noroom    = r_noroom;
        n_cnt       = r_cnt;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_mq        = r_mq;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.action == ACT_START) begin
                        n_col  = POS_W'(r_start_x);
                        n_row  = POS_W'(r_start_y);
                        n_crc  = CRC_INIT;
                        n_left = r_msg_len;
                        n_run  = 1'b0;
                    end else if (r_run) begin
                        n_sr  = {i_in_item.msg_byte, (CRC_W - BYTE_BITS)'(0)};
                        n_cb  = i_in_item.msg_byte;
                        n_cnt = CNT_W'(BYTE_BITS - 1);
                    end
                end
            end
            ST_START: begin
                n_col          = sel_col;
                n_row          = sel_row;
                n_noroom       = start_bad;
                n_dq[LN_W]     = r_width;
                n_dq[LN_H]     = r_height;
                n_dq[LN_ROW]   = sel_row;
                n_dq[LN_COL]   = sel_col;
                for (int k = 0; k < NL; k++) begin
                    n_rem[k] = '0;
                end
                n_cnt          = CNT_W'(POS_W - 1);
            end
            ST_DIV: begin
                n_dq  = div_dq;
                n_rem = div_rem;
                n_cnt = r_cnt - 1'b1;
            end
            ST_PREP: begin
                n_mq  = r_dq[LN_H] - r_dq[LN_ROW];
                n_acc = '0;
                n_cnt = CNT_W'(POS_W - 1);
            end
            ST_MUL: begin
                n_acc = {r_acc[ACC_W-2:0], 1'b0}
                      + (r_mq[POS_W-1] ? ACC_W'(r_dq[LN_W]) : '0);
                n_mq  = {r_mq[POS_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            ST_CHECK: begin
                if (emit_ok) begin
                    if (room_short) begin
                        n_out        = '0;
                        n_out.status = STAT_NO_ROOM;
                        n_out.last   = 1'b1;
                        n_out_valid  = 1'b1;
                    end else if (r_left == '0) begin
                        n_sr  = ~r_crc;
                        n_cnt = CNT_W'(CRC_BITS - 1);
                    end else begin
                        n_run               = 1'b1;
                        n_out               = blk;
                        n_out.bit_value     = 1'b0;
                        n_out.luma          = '0;
                        n_out.status        = STAT_OK;
                        n_out.last          = 1'b1;
                        n_out_valid         = 1'b1;
                    end
                end
            end
            ST_BITS: begin
                if (emit_ok) begin
                    n_out       = blk;
                    n_out_valid = 1'b1;
                    n_sr        = {r_sr[CRC_W-2:0], 1'b0};
                    n_cb        = {1'b0, r_cb[7:1]};
                    n_crc       = crc_next;
                    n_col       = step_col;
                    n_row       = step_row;
                    if (step_fail) begin
                        n_run      = 1'b0;
                        n_out.last = 1'b1;
                    end else if (r_cnt == '0) begin
                        n_left = r_left - 1'b1;
                        if (r_left == LEN_W'(1)) begin
                            n_run = 1'b0;
                            n_sr  = ~crc_next;
                            n_cnt = CNT_W'(CRC_BITS - 1);
                        end else begin
                            n_out.last = 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_CRC: begin
                if (emit_ok) begin
                    n_out       = blk;
                    n_out_valid = 1'b1;
                    n_sr        = {r_sr[CRC_W-2:0], 1'b0};
                    n_col       = step_col;
                    n_row       = step_row;
                    if (step_fail || r_cnt == '0) begin
                        n_out.last = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_row    <= n_row;
        r_crc    <= n_crc;
        r_cb     <= n_cb;
        r_sr     <= n_sr;
        r_left   <= n_left;
        r_noroom <= n_noroom;
        r_cnt    <= n_cnt;
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_mq     <= n_mq;
        r_acc    <= n_acc;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/bbse_checker.sv -----
// Port-level checks for the bit-block stamp encoder, bound to the top level.
// Depends on bbse_pkg and block_bit_stamp_encoder_top.
module bbse_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [bbse_pkg::PADDR_W-1:0] paddr,
    input logic [bbse_pkg::PDATA_W-1:0] pwdata,
    input logic [bbse_pkg::PDATA_W-1:0] prdata,
    input logic                         pready,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input bbse_pkg::t_in_item           i_in_item,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input bbse_pkg::t_out_item          o_out_item
);
    import bbse_pkg::*;

    // stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // no-room report is a lone zeroed item
    a_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == STAT_NO_ROOM |->
            o_out_item.last && !o_out_item.bit_value && o_out_item.luma == '0
            && o_out_item.block_x == '0 && o_out_item.block_y == '0)
        else $error("bad no-room item");

    // running off the frame ends the run
    a_off_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == STAT_OFF_FRAME |-> o_out_item.last)
        else $error("off-frame item not last");

    // a start keeps the input side busy for the capacity check
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.action == ACT_START |=> !o_in_ready)
        else $error("input accepted during start");

endmodule

bind block_bit_stamp_encoder_top bbse_checker u_bbse_checker (.*);

// ----- bench/block_bit_stamp_encoder_top_tb.sv -----
// Self-checking bench for block_bit_stamp_encoder_top: directed table, then random runs,
// every block compared against a built-in stamping predictor.
// Depends on bbse_pkg and the RTL top level.
`timescale 1ns / 100ps

module block_bit_stamp_encoder_top_tb;
    import bbse_pkg::*;

    localparam int unsigned BLK = BLOCK_SIZE_DEF;
    localparam int SETTLE_CYC   = 64;
    localparam int HOLD_CYC     = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RAND_ITEMS   = 360;

    typedef struct packed {
        logic      is_cfg;
        t_reg_idx  ridx;
        logic [15:0] rval;
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_plan_row;

    localparam t_out_item NO_ROOM_BLK = '{12'd0, 12'd0, 25'd0, 1'b0, 8'd0, STAT_NO_ROOM, 1'b1};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;

    block_bit_stamp_encoder_top #(.BLOCK_SIZE(BLK)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // shadow registers
    logic [POS_W-1:0]    cfg_width  = WIDTH_RST;
    logic [POS_W-1:0]    cfg_height = HEIGHT_RST;
    logic [STRIDE_W-1:0] cfg_stride = STRIDE_RST;
    logic [CRD_W-1:0]    cfg_sx     = '0;
    logic [CRD_W-1:0]    cfg_sy     = '0;
    logic [LEN_W-1:0]    cfg_len    = '0;
    logic [LUMA_W-1:0]   cfg_on     = ON_RST;
    logic [LUMA_W-1:0]   cfg_off    = OFF_RST;

    // stamper state
    int unsigned  cur_col = 0;
    int unsigned  cur_row = 0;
    logic [31:0]  crc_acc = CRC_INIT;
    logic [11:0]  left_bytes = '0;
    bit           run_on = 1'b0;

    t_out_item item_res[$];
    t_out_item stamp_q[$];
    t_plan_row send_q[$];
    t_plan_row plan[$];
    t_plan_row on_wire;

    int  err_cnt = 0;
    int  acc_cnt = 0;
    int  fed_cnt = 0;
    int  blk_cnt = 0;
    int  no_room_cnt = 0;
    int  off_frame_cnt = 0;
    int  send_gap = 0;
    int  stall_cnt = 0;
    int  hold_cnt = 0;
    int  quiet_cycles = 0;
    bit  hold_req = 1'b0;
    bit  calm = 1'b0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;

    function automatic t_out_item make_block(int unsigned x, y, logic b, logic [7:0] l,
                                             logic [1:0] s);
        t_out_item r;
        logic [63:0] a;
        a = 64'(x) + 64'(y) * 64'(cfg_stride);
        r.block_x = x[11:0];
        r.block_y = y[11:0];
        r.block_address = a[24:0];
        r.bit_value = b;
        r.luma = l;
        r.status = s;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic bit walk_cursor();
        cur_col += BLK;
        if (cur_col + BLK > cfg_width) begin
            cur_row += BLK;
            if (cur_row + BLK > cfg_height) begin
                cur_row -= BLK;
                cur_col -= BLK;
                return 1'b0;
            end
            cur_col = 0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned blocks_free();
        int unsigned w, h;
        if (cur_row + BLK > cfg_height) return 0;
        if (cur_col + BLK > cfg_width && !walk_cursor()) return 0;
        w = cfg_width / BLK;
        h = cfg_height / BLK;
        return (w * h - w * (cur_row / BLK)) - cur_col / BLK;
    endfunction

    function automatic bit stamp_bits(logic [7:0] v);
        int unsigned x, y;
        bit ok;
        for (int i = 7; i >= 0; i--) begin
            x = cur_col;
            y = cur_row;
            ok = walk_cursor();
            item_res.push_back(make_block(x, y, v[i], v[i] ? cfg_on : cfg_off,
                                          ok ? STAT_OK : STAT_OFF_FRAME));
            if (!ok) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] v);
        c ^= {24'd0, v};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void stamp_tail();
        logic [31:0] c;
        c = ~crc_acc;
        for (int s = 3; s >= 0; s--)
            if (!stamp_bits(c[s*8 +: 8])) return;
    endfunction

    function automatic void stamp_model(t_in_item it);
        t_out_item tmp;
        item_res.delete();
        if (it.action == ACT_START) begin
            cur_col = cfg_sx;
            cur_row = cfg_sy;
            crc_acc = CRC_INIT;
            left_bytes = cfg_len;
            run_on = 1'b0;
            if (blocks_free() < 8 * (32'(cfg_len) + 4)) begin
                item_res.push_back(make_block(0, 0, 1'b0, 8'd0, STAT_NO_ROOM));
            end else if (left_bytes == 0) begin
                stamp_tail();
            end else begin
                run_on = 1'b1;
                item_res.push_back(make_block(cur_col, cur_row, 1'b0, 8'd0, STAT_OK));
            end
        end else if (run_on) begin
            crc_acc = crc_step(crc_acc, it.msg_byte);
            if (!stamp_bits(it.msg_byte)) begin
                run_on = 1'b0;
            end else begin
                left_bytes = left_bytes - 12'd1;
                if (left_bytes == 0) begin
                    run_on = 1'b0;
                    stamp_tail();
                end
            end
        end
        if (item_res.size() > 0) begin
            tmp = item_res.pop_back();
            tmp.last = 1'b1;
            item_res.push_back(tmp);
        end
    endfunction

    function automatic void check_block(t_out_item got);
        t_out_item want;
        bit bad;
        if (stamp_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("unexpected block x=%0d y=%0d addr=%0d bit=%0d luma=%0d st=%0d last=%0d",
                         got.block_x, got.block_y, got.block_address, got.bit_value,
                         got.luma, got.status, got.last);
            return;
        end
        want = stamp_q.pop_front();
        blk_cnt++;
        if (want.status == STAT_NO_ROOM) no_room_cnt++;
        if (want.status == STAT_OFF_FRAME) off_frame_cnt++;
        bad = got.block_x !== want.block_x || got.block_y !== want.block_y ||
              got.block_address !== want.block_address || got.bit_value !== want.bit_value ||
              got.luma !== want.luma || got.status !== want.status || got.last !== want.last;
        if (bad) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $display("block mismatch: got x=%0d y=%0d addr=%0d bit=%0d luma=%0d st=%0d last=%0d",
                         got.block_x, got.block_y, got.block_address, got.bit_value,
                         got.luma, got.status, got.last);
                $display("           expected x=%0d y=%0d addr=%0d bit=%0d luma=%0d st=%0d last=%0d",
                         want.block_x, want.block_y, want.block_address, want.bit_value,
                         want.luma, want.status, want.last);
            end
        end
    endfunction

    function automatic t_plan_row cfg_row(t_reg_idx idx, int unsigned v);
        t_plan_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.ridx = idx;
        r.rval = v[15:0];
        return r;
    endfunction

    function automatic t_plan_row item_row(logic act, logic [7:0] v);
        t_plan_row r;
        r = '0;
        r.item.action = act;
        r.item.msg_byte = v;
        return r;
    endfunction

    function automatic t_plan_row seen_row(logic act, logic [7:0] v, t_out_item w);
        t_plan_row r;
        r = item_row(act, v);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic t_out_item blk(int unsigned x, y, a, logic b, logic [7:0] l,
                                      logic [1:0] s, logic lst);
        t_out_item r;
        r.block_x = x[11:0];
        r.block_y = y[11:0];
        r.block_address = a[24:0];
        r.bit_value = b;
        r.luma = l;
        r.status = s;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val[POS_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = val[POS_W-1:0];
            REG_ROW_STRIDE:   cfg_stride = val[STRIDE_W-1:0];
            REG_START_X:      cfg_sx     = val[CRD_W-1:0];
            REG_START_Y:      cfg_sy     = val[CRD_W-1:0];
            REG_MSG_LEN:      cfg_len    = val[LEN_W-1:0];
            REG_ON_LEVEL:     cfg_on     = val[LUMA_W-1:0];
            REG_OFF_LEVEL:    cfg_off    = val[LUMA_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every item is in and every block is out, then let the block go quiet
    task automatic settle();
        while (send_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (stamp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // sender: predicts each accepted item and drives the next one, with random gaps
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            acc_cnt++;
            stamp_model(on_wire.item);
            if (on_wire.typed && item_res.size() > 0) item_res[0] = on_wire.want;
            if (item_res.size() > 0) fed_cnt++;
            foreach (item_res[k]) stamp_q.push_back(item_res[k]);
            if (!calm && send_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end
        if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                on_wire = send_q.pop_front();
                i_in_item <= on_wire.item;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) check_block(o_out_item);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYC;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && recv_idle && $urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 5);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : main_seq
        int unsigned w, h, stride, sx, sy, len, hb, wb, msgs, nb, r;
        int dir_fed, phase;
        bit dirty;
        dirty = 1'b0;
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan = {
            item_row(ACT_BYTE, 8'hFF),                               // byte while idle
            seen_row(ACT_START, 8'h00, blk(0, 0, 0, 0, 0, STAT_OK, 0)),  // empty message
            cfg_row(REG_MSG_LEN, 2),
            seen_row(ACT_START, 8'hA5, blk(0, 0, 0, 0, 0, STAT_OK, 1)),
            item_row(ACT_BYTE, 8'h00),
            item_row(ACT_BYTE, 8'hFF),
            item_row(ACT_BYTE, 8'h80),                               // run over, ignored
            cfg_row(REG_MSG_LEN, 4095),
            seen_row(ACT_START, 8'h00, NO_ROOM_BLK),
            cfg_row(REG_FRAME_WIDTH, 4096),
            cfg_row(REG_FRAME_HEIGHT, 4096),
            cfg_row(REG_ROW_STRIDE, 8192),
            cfg_row(REG_START_X, 4095),
            cfg_row(REG_START_Y, 4088),
            cfg_row(REG_MSG_LEN, 1),
            seen_row(ACT_START, 8'h00, blk(0, 4092, 33521664, 0, 0, STAT_OK, 1)),
            item_row(ACT_BYTE, 8'h01),
            cfg_row(REG_START_Y, 4092),
            cfg_row(REG_MSG_LEN, 0),
            seen_row(ACT_START, 8'h00, NO_ROOM_BLK),
            cfg_row(REG_START_X, 0),
            cfg_row(REG_START_Y, 0),
            cfg_row(REG_MSG_LEN, 4095),
            seen_row(ACT_START, 8'h00, blk(0, 0, 0, 0, 0, STAT_OK, 1)),
            item_row(ACT_BYTE, 8'hC3),
            item_row(ACT_BYTE, 8'h7E),
            seen_row(ACT_START, 8'h00, blk(0, 0, 0, 0, 0, STAT_OK, 1)),  // restart mid-run
            cfg_row(REG_FRAME_WIDTH, 1),
            cfg_row(REG_FRAME_HEIGHT, 1),
            cfg_row(REG_MSG_LEN, 0),
            seen_row(ACT_START, 8'h00, NO_ROOM_BLK),                 // tiny frame
            cfg_row(REG_FRAME_WIDTH, 40),
            cfg_row(REG_FRAME_HEIGHT, 16),
            cfg_row(REG_ROW_STRIDE, 40),
            cfg_row(REG_MSG_LEN, 1),
            cfg_row(REG_ON_LEVEL, 8'hA5),
            cfg_row(REG_OFF_LEVEL, 8'h3C),
            seen_row(ACT_START, 8'h00, blk(0, 0, 0, 0, 0, STAT_OK, 1)),
            item_row(ACT_BYTE, 8'h96),                               // exact fit, runs off
            item_row(ACT_BYTE, 8'h11),                               // after failure
            cfg_row(REG_FRAME_WIDTH, 32),
            cfg_row(REG_MSG_LEN, 0),
            item_row(ACT_START, 8'h00)                               // exact fit, CRC only
        };

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                if (dirty) settle();
                dirty = 1'b0;
                reg_write(plan[k].ridx, 32'(plan[k].rval));
            end else begin
                send_q.push_back(plan[k]);
                dirty = 1'b1;
            end
        end
        settle();
        dir_fed = fed_cnt;

        while (fed_cnt < dir_fed + RAND_ITEMS) begin
            if (fed_cnt > dir_fed + RAND_ITEMS - 60) calm = 1'b1;
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            r = (phase == 1) ? 0 : $urandom_range(0, 3);
            case (r)
                0: begin
                    w = $urandom_range(64, 4096);
                    h = $urandom_range(64, 4096);
                    sx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
                    sy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
                end
                1: begin
                    w = $urandom_range(1, 48);
                    h = $urandom_range(1, 24);
                    sx = $urandom_range(0, 20);
                    sy = $urandom_range(0, 12);
                    len = $urandom_range(0, 2);
                end
                2: begin
                    len = $urandom_range(0, 2);
                    hb = 1 << $urandom_range(0, 3);
                    wb = 8 * (len + 4) / hb;
                    w = 4 * wb + $urandom_range(0, 3);
                    h = 4 * hb + $urandom_range(0, 3);
                    sx = ($urandom_range(0, 3) == 0) ? 4 : 0;
                    sy = 0;
                end
                default: begin
                    w = 4096;
                    h = 4096;
                    sx = $urandom_range(4088, 4095);
                    sy = $urandom_range(4076, 4095);
                    len = $urandom_range(0, 1);
                end
            endcase
            case ($urandom_range(0, 3))
                0: stride = 1;
                1: stride = 8192;
                default: stride = $urandom_range(1, 8192);
            endcase
            if (phase == 1 && len < 4) len = 4;
            settle();
            reg_write(REG_FRAME_WIDTH, w);
            reg_write(REG_FRAME_HEIGHT, h);
            reg_write(REG_ROW_STRIDE, stride);
            reg_write(REG_START_X, sx);
            reg_write(REG_START_Y, sy);
            reg_write(REG_MSG_LEN, len);
            reg_write(REG_ON_LEVEL, rand_level());
            reg_write(REG_OFF_LEVEL, rand_level());
            if (phase == 1) hold_req = 1'b1;
            msgs = (phase == 1) ? 8 : $urandom_range(2, 6);
            repeat (msgs) begin
                r = $urandom_range(0, 9);
                if (r == 0) send_q.push_back(item_row(ACT_BYTE, rand_byte()));
                send_q.push_back(item_row(ACT_START, rand_byte()));
                nb = len;
                if (r == 1 && nb > 0) nb = $urandom_range(0, nb - 1);   // cut short, restart
                repeat (nb) send_q.push_back(item_row(ACT_BYTE, rand_byte()));
                if (r == 2) send_q.push_back(item_row(ACT_BYTE, rand_byte()));
            end
            phase++;
        end
        settle();

        $display("covered %0d items (%0d producing blocks) across %0d random settings",
                 acc_cnt, fed_cnt, phase);
        $display("checked %0d blocks: %0d no-room, %0d off-frame, %0d mismatches",
                 blk_cnt, no_room_cnt, off_frame_cnt, err_cnt);
        if (err_cnt == 0 && stamp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
